FILE: design/afk_pkg.sv
// Package for the arm forward kinematics block: widths, constants, CORDIC table.
package afk_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int AngleBitsDefault   = 16;
    localparam int CordicMaxSteps     = 24;

    localparam int RegWidth   = 18;
    localparam int AngleWidth = 16;
    localparam int OutWidth   = 20;
    localparam int RegCount   = 6;
    localparam int RegIdxWidth = 3;

    // Register indexes on the configuration port.
    localparam logic [RegIdxWidth-1:0] REG_BASE_HEIGHT    = 3'd0;
    localparam logic [RegIdxWidth-1:0] REG_UPPER_ARM      = 3'd1;
    localparam logic [RegIdxWidth-1:0] REG_FOREARM        = 3'd2;
    localparam logic [RegIdxWidth-1:0] REG_TOOL           = 3'd3;
    localparam logic [RegIdxWidth-1:0] REG_LATERAL_OFFSET = 3'd4;
    localparam logic [RegIdxWidth-1:0] REG_WRIST_OFFSET   = 3'd5;

    // CORDIC datapath: Q30 values, 34 bits signed covers the gain-scaled vector.
    localparam int CordicWidth = 34;
    localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;

    localparam logic signed [OutWidth-1:0] OutMax = 20'sd524287;
    localparam logic signed [OutWidth-1:0] OutMin = -20'sd524288;

    typedef logic signed [CordicWidth-1:0] cordic_t;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic cordic_t atan_entry(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
                3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
                6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
                9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
                12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
                15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
                18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
                21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            atan_entry = cordic_t'({2'b00, v});
        end
    endfunction

    // Clamp a wide sum to the output range.
    function automatic logic signed [OutWidth-1:0] saturate(input logic signed [63:0] v);
        begin
            if (v > 64'(OutMax)) begin
                saturate = OutMax;
            end else if (v < 64'(OutMin)) begin
                saturate = OutMin;
            end else begin
                saturate = v[OutWidth-1:0];
            end
        end
    endfunction

endpackage

FILE: design/afk_sincos.sv
// Pipelined rotation-mode CORDIC: one binary angle in, Q30 cosine and sine out.
module afk_sincos
    import afk_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault,
    parameter int ANGLE_BITS   = AngleBitsDefault
) (
    input  logic                  aclk,
    input  logic                  ce,
    input  logic [AngleWidth-1:0] angle,
    output cordic_t               cos_out,
    output cordic_t               sin_out
);

    localparam int Steps = (CORDIC_STEPS < CordicMaxSteps) ? CORDIC_STEPS : CordicMaxSteps;

    cordic_t     x_reg [Steps+1];
    cordic_t     y_reg [Steps+1];
    cordic_t     z_reg [Steps+1];
    logic [1:0]  q_reg [Steps+1];

    logic [31:0] phase;
    logic [31:0] shifted;

    // Fold to the nearest quadrant and keep the residual angle.
    always_comb begin
        phase   = {angle, 16'h0000} & (32'hFFFF_FFFF << (32 - ANGLE_BITS));
        shifted = phase + 32'h2000_0000;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg[0] <= CordicGain;
            y_reg[0] <= '0;
            z_reg[0] <= cordic_t'({4'b0000, shifted[29:0]}) - cordic_t'(34'sh2000_0000);
            q_reg[0] <= shifted[31:30];
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < Steps; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (!z_reg[i][CordicWidth-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // Undo the quadrant fold.
    always_comb begin
        case (q_reg[Steps])
            2'd0: begin cos_out = x_reg[Steps];  sin_out = y_reg[Steps];  end
            2'd1: begin cos_out = -y_reg[Steps]; sin_out = x_reg[Steps];  end
            2'd2: begin cos_out = -x_reg[Steps]; sin_out = -y_reg[Steps]; end
            default: begin cos_out = y_reg[Steps]; sin_out = -x_reg[Steps]; end
        endcase
    end

endmodule

FILE: design/arm_forward_kinematics_top.sv
// Top level of the four-joint arm forward kinematics pipeline.
//
// Usage: a request on the s_ channel carries four 16-bit binary joint angles
// (65536 = one turn). The m_ channel returns the tool tip position x, y, z in
// metres times 65536, saturated to 20-bit signed. One result per request.
// Link lengths and offsets are set on the plain write port (cfg_we, cfg_addr,
// cfg_wdata), register i at index i; write only while the pipeline is empty.
// Throughput: one request per cycle while m_tready does not stall the output.
// The sine/cosine pipelines are followed by product, planar-sum, rounding,
// rotation product, rotation-sum and output stages.
// The whole pipeline advances as one: when the receiver holds m_tready low
// with a result waiting, every stage holds, and s_tready drops only then.
// Reset clears the valid bits and loads the register reset values.
module arm_forward_kinematics_top
    import afk_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault,
    parameter int ANGLE_BITS   = AngleBitsDefault
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // base_angle[15:0], shoulder_angle[31:16], elbow_angle[47:32], wrist_angle[63:48]
    input  logic [63:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tip_x[19:0], tip_y[39:20], tip_z[59:40], zero fill[63:60]
    output logic [63:0]            m_tdata,
    input  logic                   cfg_we,
    input  logic [RegIdxWidth-1:0] cfg_addr,
    input  logic [RegWidth-1:0]    cfg_wdata
);

    localparam int Steps    = (CORDIC_STEPS < CordicMaxSteps) ? CORDIC_STEPS : CordicMaxSteps;
    localparam int Latency  = Steps + 7;

    logic signed [RegWidth-1:0] regs_reg [RegCount];
    logic [Latency-1:0] valid_reg;
    logic ce;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[REG_BASE_HEIGHT]    <= 18'sd16384;
            regs_reg[REG_UPPER_ARM]      <= 18'sd13107;
            regs_reg[REG_FOREARM]        <= 18'sd13107;
            regs_reg[REG_TOOL]           <= 18'sd9830;
            regs_reg[REG_LATERAL_OFFSET] <= -18'sd2621;
            regs_reg[REG_WRIST_OFFSET]   <= -18'sd2621;
        end else if (cfg_we && (cfg_addr < 3'(RegCount))) begin
            regs_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Whole pipeline holds only when the last stage is full and not taken.
    assign ce       = !(valid_reg[Latency-1] && !m_tready);
    assign s_tready = ce;
    assign m_tvalid = valid_reg[Latency-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[Latency-2:0], s_tvalid};
        end
    end

    // Joint angle sums.
    logic [AngleWidth-1:0] a1, a12, a123, ab;
    always_comb begin
        ab   = s_tdata[15:0];
        a1   = s_tdata[31:16];
        a12  = a1 + s_tdata[47:32];
        a123 = a12 + s_tdata[63:48];
    end

    cordic_t c1, s1, c12, s12, c123, s123, cb, sb;

    afk_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_sc1 (
        .aclk(aclk), .ce(ce), .angle(a1), .cos_out(c1), .sin_out(s1));
    afk_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_sc12 (
        .aclk(aclk), .ce(ce), .angle(a12), .cos_out(c12), .sin_out(s12));
    afk_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_sc123 (
        .aclk(aclk), .ce(ce), .angle(a123), .cos_out(c123), .sin_out(s123));
    afk_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_scb (
        .aclk(aclk), .ce(ce), .angle(ab), .cos_out(cb), .sin_out(sb));

    // Base sine and cosine wait for the planar result.
    cordic_t cb_d_reg [3];
    cordic_t sb_d_reg [3];

    // Stage P: one register x Q30 product per multiplier.
    logic signed [63:0] px1_reg, px2_reg, px3_reg, px4_reg;
    logic signed [63:0] pz1_reg, pz2_reg, pz3_reg, pz4_reg;
    // Stage S1 / S2: planar sums, then rounding.
    logic signed [63:0] sx_reg, sz_reg;
    logic signed [63:0] x5_reg, z5_reg;
    // Stage R: rotation products, then sums, then outputs.
    logic signed [63:0] rx1_reg, rx2_reg, ry1_reg, ry2_reg, z5d_reg;
    logic signed [63:0] xf_reg, yf_reg, zf_reg;
    logic [63:0] out_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            px1_reg <= 64'(regs_reg[REG_UPPER_ARM]) * 64'(c1);
            px2_reg <= 64'(regs_reg[REG_FOREARM]) * 64'(c12);
            px3_reg <= 64'(regs_reg[REG_WRIST_OFFSET]) * 64'(s123);
            px4_reg <= 64'(regs_reg[REG_TOOL]) * 64'(c123);
            pz1_reg <= 64'(regs_reg[REG_UPPER_ARM]) * 64'(s1);
            pz2_reg <= 64'(regs_reg[REG_FOREARM]) * 64'(s12);
            pz3_reg <= 64'(regs_reg[REG_WRIST_OFFSET]) * 64'(c123);
            pz4_reg <= 64'(regs_reg[REG_TOOL]) * 64'(s123);
            cb_d_reg[0] <= cb;
            sb_d_reg[0] <= sb;
            for (int k = 1; k < 3; k++) begin
                cb_d_reg[k] <= cb_d_reg[k-1];
                sb_d_reg[k] <= sb_d_reg[k-1];
            end

            sx_reg <= px1_reg + px2_reg + px3_reg + px4_reg;
            sz_reg <= (64'(regs_reg[REG_BASE_HEIGHT]) <<< 30) - pz1_reg - pz2_reg
                      + pz3_reg - pz4_reg;

            x5_reg <= (sx_reg + 64'sh2000_0000) >>> 30;
            z5_reg <= (sz_reg + 64'sh2000_0000) >>> 30;

            // The planar x of four links fits in 21 signed bits.
            rx1_reg <= 64'($signed(x5_reg[20:0])) * 64'(cb_d_reg[2]);
            rx2_reg <= 64'(regs_reg[REG_LATERAL_OFFSET]) * 64'(sb_d_reg[2]);
            ry1_reg <= 64'($signed(x5_reg[20:0])) * 64'(sb_d_reg[2]);
            ry2_reg <= 64'(regs_reg[REG_LATERAL_OFFSET]) * 64'(cb_d_reg[2]);
            z5d_reg <= z5_reg;

            xf_reg <= (rx1_reg - rx2_reg + 64'sh2000_0000) >>> 30;
            yf_reg <= (ry1_reg + ry2_reg + 64'sh2000_0000) >>> 30;
            zf_reg <= z5d_reg;

            out_reg <= {4'b0000, saturate(zf_reg), saturate(yf_reg), saturate(xf_reg)};
        end
    end

    assign m_tdata = out_reg;

    // A stalled result stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    // Input is refused only while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without output stall");
    // The fill bits of the result stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:60] == 4'b0000)
        else $error("result fill bits set");

endmodule

FILE: test/arm_forward_kinematics_top_test.sv
// Self-checking testbench for the arm forward kinematics pipeline.
module arm_forward_kinematics_top_test
    import afk_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [OutWidth-1:0] x;
        logic signed [OutWidth-1:0] y;
        logic signed [OutWidth-1:0] z;
    } tip_t;

    // Predicts tool tip positions and checks them in request order.
    class tip_scoreboard;
        longint geometry[RegCount];
        tip_t   tips_due[$];
        int     fails;

        function new();
            geometry = '{16384, 13107, 13107, 9830, -2621, -2621};
            fails = 0;
        endfunction

        function void write_reg(logic [RegIdxWidth-1:0] idx, logic [RegWidth-1:0] val);
            // Indexes past the last register are ignored by the block.
            if (idx < RegCount) begin
                geometry[idx] = longint'($signed(val));
            end
        endfunction

        // Rotation-mode CORDIC on a quadrant-folded binary angle, Q30 results.
        function void sin_cos(input logic [15:0] ang, output longint c, output longint s);
            logic [31:0] phase;
            logic [1:0]  quad;
            longint x, y, z, dx, dy, tab;
            phase = {ang, 16'h0} + 32'h2000_0000;
            quad = phase[31:30];
            z = longint'({2'b00, phase[29:0]}) - 64'h2000_0000;
            x = CordicGain;
            y = 0;
            for (int i = 0; i < CordicStepsDefault; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                tab = atan_entry(i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= tab;
                end else begin
                    x += dx; y -= dy; z += tab;
                end
            end
            case (quad)
                2'd0: begin c = x; s = y; end
                2'd1: begin c = -y; s = x; end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        endfunction

        function longint to_q16(longint v);
            return (v + 64'sh2000_0000) >>> 30;
        endfunction

        function logic signed [OutWidth-1:0] clamp(longint v);
            if (v > 524287) return OutMax;
            if (v < -524288) return OutMin;
            return v[OutWidth-1:0];
        endfunction

        function void note_angles(logic [63:0] req);
            logic [15:0] a1, a12, a123;
            longint c1, s1, c12, s12, c123, s123, cb, sb, x5, z5;
            tip_t t;
            a1 = req[31:16];
            a12 = a1 + req[47:32];
            a123 = a12 + req[63:48];
            sin_cos(a1, c1, s1);
            sin_cos(a12, c12, s12);
            sin_cos(a123, c123, s123);
            sin_cos(req[15:0], cb, sb);
            x5 = to_q16(geometry[1] * c1 + geometry[2] * c12 + geometry[5] * s123
                        + geometry[3] * c123);
            z5 = to_q16(geometry[0] * 64'sd1073741824 - geometry[1] * s1 - geometry[2] * s12
                        + geometry[5] * c123 - geometry[3] * s123);
            t.x = clamp(to_q16(x5 * cb - geometry[4] * sb));
            t.y = clamp(to_q16(x5 * sb + geometry[4] * cb));
            t.z = clamp(z5);
            tips_due.push_back(t);
        endfunction

        function void check_tip(logic [63:0] res);
            tip_t want;
            if (tips_due.size() == 0) begin
                $error("unexpected result %h", res);
                fails++;
                return;
            end
            want = tips_due.pop_front();
            if (res[19:0] !== want.x) begin
                $error("tip_x expected %0d got %0d", want.x, $signed(res[19:0]));
                fails++;
            end
            if (res[39:20] !== want.y) begin
                $error("tip_y expected %0d got %0d", want.y, $signed(res[39:20]));
                fails++;
            end
            if (res[59:40] !== want.z) begin
                $error("tip_z expected %0d got %0d", want.z, $signed(res[59:40]));
                fails++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [63:0]            m_tdata;
    logic                   cfg_we;
    logic [RegIdxWidth-1:0] cfg_addr;
    logic [RegWidth-1:0]    cfg_wdata;

    tip_scoreboard sb;
    bit            calm;
    int            stalled_cycles;

    arm_forward_kinematics_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: too many cycles without any accepted request or result.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= 5000) begin
            $display("arm_forward_kinematics_top_test: FAIL");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Result receiver with random stalls.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_tip(m_tdata);
            @(negedge aclk);
        end
    end

    // Raises the write enable for one register write; the caller drops it after the last write.
    task automatic write_geometry(logic [RegIdxWidth-1:0] idx, logic [RegWidth-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic send_angles(logic [63:0] req);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= req;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_angles(req);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] marks[9] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                  16'h2000, 16'h1FFF, 16'hE000, 16'h6000};
        if ($urandom_range(0, 7) == 0) return marks[$urandom_range(0, 8)];
        return 16'($urandom);
    endfunction

    // Let the pipeline drain before touching the geometry.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.tips_due.size() != 0) @(negedge aclk);
        repeat (CordicStepsDefault + 20) @(negedge aclk);
    endtask

    initial begin
        logic [RegWidth-1:0] setting;
        logic [15:0] marks[8];
        marks = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                  16'hC000, 16'h2000, 16'h1FFF, 16'hE000};
        sb = new();
        calm = 1'b0;
        stalled_cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests at the reset geometry: quadrant edges and fold points.
        foreach (marks[i]) begin
            send_angles({marks[i], marks[(i + 3) % 8], marks[(i + 5) % 8], marks[i]});
        end
        send_angles(64'hFFFF_FFFF_FFFF_FFFF);
        send_angles(64'h0);
        send_angles(64'h2000_2000_2000_2000);

        // Each phase sets a geometry, then runs random requests through it.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                drain();
                for (int r = 0; r < RegCount; r++) begin
                    case (phase)
                        1: setting = 18'h1FFFF;
                        2: setting = 18'h20000;
                        3: setting = r[0] ? 18'h1FFFF : 18'h20000;
                        4: setting = 18'($urandom_range(0, 40000));
                        default: setting = 18'($urandom);
                    endcase
                    write_geometry(RegIdxWidth'(r), setting);
                end
                // Writes to unused indexes must change nothing.
                write_geometry(RegIdxWidth'(6), 18'($urandom));
                write_geometry(RegIdxWidth'(7), 18'($urandom));
                cfg_we <= 1'b0;
            end
            calm = (phase == 2);
            for (int n = 0; n < 325; n++) begin
                send_angles({pick_angle(), pick_angle(), pick_angle(), pick_angle()});
            end
        end

        drain();
        if (sb.fails == 0) begin
            $display("arm_forward_kinematics_top_test: PASS");
        end else begin
            $display("arm_forward_kinematics_top_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/afk_pkg.sv
design/afk_sincos.sv
design/arm_forward_kinematics_top.sv
test/arm_forward_kinematics_top_test.sv
